// File: design/bankers_safety_grant_top_assert.svh
// assertion macros used by the checker file
`ifndef BANKERS_SAFETY_GRANT_TOP_ASSERT_SVH
`define BANKERS_SAFETY_GRANT_TOP_ASSERT_SVH

// property holds on every clock edge out of reset
`define BSG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define BSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bsg_pkg.sv
// shared constants, types and codes of the safety grant block
`default_nettype none
package bsg_pkg;
	localparam int PROCS = 8;
	localparam int RES = 4;
	localparam int COUNT_BITS = 8;
	localparam int MAX_OUT = 8;
	localparam int LIM_PROCS = (PROCS < MAX_OUT) ? PROCS : MAX_OUT;
	localparam int PW = $clog2(PROCS);
	localparam int CW = $clog2(PROCS + 1);
	localparam int MW = $clog2(RES + 1);
	localparam int WW = COUNT_BITS + $clog2(PROCS + 1);

	localparam logic [1:0] KIND_HELD = 2'd0;
	localparam logic [1:0] KIND_CEIL = 2'd1;
	localparam logic [1:0] KIND_FREE = 2'd2;
	localparam logic [1:0] KIND_REQ = 2'd3;

	localparam logic CFG_PROCS = 1'b0;
	localparam logic CFG_RES = 1'b1;

	typedef enum logic [2:0] {
		ST_LOADED = 3'd0,
		ST_GRANTED = 3'd1,
		ST_EXCEEDS = 3'd2,
		ST_WAIT = 3'd3,
		ST_UNSAFE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_EMIT_ONE,
		S_EMIT_SEQ
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    load;
		logic    start_scan;
		logic    scan_step;
		logic    commit;
		logic    emit_valid;
		status_t emit_status;
		logic    emit_seq;
	} cmd_t;

	typedef struct packed {
		logic is_request;
		logic exceed;
		logic must_wait;
		logic safe;
		logic stuck;
		logic out_free;
		logic emit_last;
	} sts_t;
endpackage
`default_nettype wire

// File: design/bsg_ctrl.sv
// controller state machine sequencing check, safety scan and result output
`default_nettype none
module bsg_ctrl import bsg_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t  state_q, state_d;
	status_t res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q <= ST_LOADED;
		end else begin
			state_q <= state_d;
			res_q <= res_d;
		end
	end

	always_comb begin
		state_d = state_q;
		res_d = res_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.emit_status = ST_LOADED;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.is_request) begin
					cmd.load = 1'b1;
					res_d = ST_LOADED;
					state_d = S_EMIT_ONE;
				end else if (sts.exceed) begin
					res_d = ST_EXCEEDS;
					state_d = S_EMIT_ONE;
				end else if (sts.must_wait) begin
					res_d = ST_WAIT;
					state_d = S_EMIT_ONE;
				end else begin
					cmd.start_scan = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.safe) begin
					cmd.commit = 1'b1;
					state_d = S_EMIT_SEQ;
				end else if (sts.stuck) begin
					res_d = ST_UNSAFE;
					state_d = S_EMIT_ONE;
				end
			end
			S_EMIT_ONE: begin
				if (sts.out_free) begin
					cmd.emit_valid = 1'b1;
					cmd.emit_status = res_q;
					state_d = S_IDLE;
				end
			end
			S_EMIT_SEQ: begin
				if (sts.out_free) begin
					cmd.emit_valid = 1'b1;
					cmd.emit_status = ST_GRANTED;
					cmd.emit_seq = 1'b1;
					if (sts.emit_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

// File: design/bsg_dp.sv
// datapath: tables, config registers, row-serial safety scan and output register
`default_nettype none
module bsg_dp import bsg_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire         cfg_addr,
	input  wire  [3:0]  cfg_wdata,
	input  wire  [1:0]  in_kind,
	input  wire  [2:0]  in_proc,
	input  wire  [31:0] in_amt,
	input  wire         out_ready,
	output logic        out_valid,
	output logic [2:0]  out_status,
	output logic [2:0]  out_seq,
	output logic        out_last,
	input  cmd_t        cmd,
	output sts_t        sts
);
	logic [3:0] active_procs_q;
	logic [2:0] active_res_q;
	logic [COUNT_BITS-1:0] held_q [PROCS][RES];
	logic [COUNT_BITS-1:0] ceil_q [PROCS][RES];
	logic [COUNT_BITS-1:0] free_q [RES];

	logic [1:0] kind_q;
	logic [2:0] proc_q;
	logic [7:0] amt_q [RES];
	logic [COUNT_BITS-1:0] thp_q [RES];
	logic [WW-1:0] work_q [RES];
	logic [PW-1:0] seq_q [PROCS];
	logic [PROCS-1:0] done_q;
	logic [PW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] emit_q;
	logic found_q;
	logic out_valid_q;
	logic [2:0] out_status_q, out_seq_q;
	logic out_last_q;

	logic [CW-1:0] n;
	logic [MW-1:0] m;
	logic [PW-1:0] pidx;
	logic [COUNT_BITS-1:0] row_h [RES];
	logic row_ok, pass_end, exceed_c, wait_c;
	logic [CW-1:0] cnt_next;

	function automatic logic [COUNT_BITS-1:0] need_f(logic [COUNT_BITS-1:0] c,
		logic [COUNT_BITS-1:0] h);
		return (c > h) ? c - h : '0;
	endfunction

	always_comb begin
		if (active_procs_q == 4'd0) n = CW'(1);
		else if (int'(active_procs_q) > LIM_PROCS) n = CW'(LIM_PROCS);
		else n = CW'(active_procs_q);
		if (active_res_q == 3'd0) m = MW'(1);
		else if (int'(active_res_q) > RES) m = MW'(RES);
		else m = MW'(active_res_q);
	end

	assign pidx = PW'(proc_q);

	always_comb begin
		exceed_c = (int'(proc_q) >= int'(n));
		wait_c = 1'b0;
		for (int r = 0; r < RES; r++) begin
			if (r < int'(m)) begin
				if (WW'(amt_q[r]) > WW'(need_f(ceil_q[pidx][r], held_q[pidx][r])))
					exceed_c = 1'b1;
				if (WW'(amt_q[r]) > WW'(free_q[r]))
					wait_c = 1'b1;
			end
		end
	end

	always_comb begin
		row_ok = !done_q[idx_q];
		for (int r = 0; r < RES; r++) begin
			row_h[r] = (idx_q == pidx) ? thp_q[r] : held_q[idx_q][r];
			if (r < int'(m) && WW'(need_f(ceil_q[idx_q][r], row_h[r])) > work_q[r])
				row_ok = 1'b0;
		end
		pass_end = (CW'(idx_q) + CW'(1)) == n;
		cnt_next = cnt_q + CW'(row_ok);
	end

	assign sts.is_request = (kind_q == KIND_REQ);
	assign sts.exceed = exceed_c;
	assign sts.must_wait = wait_c;
	assign sts.safe = pass_end && (cnt_next == n);
	assign sts.stuck = pass_end && !(found_q || row_ok);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.emit_last = (emit_q + CW'(1)) == n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_procs_q <= 4'd8;
			active_res_q <= 3'd4;
			out_valid_q <= 1'b0;
			done_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			emit_q <= '0;
			found_q <= 1'b0;
			for (int i = 0; i < PROCS; i++) begin
				for (int r = 0; r < RES; r++) begin
					held_q[i][r] <= '0;
					ceil_q[i][r] <= '0;
				end
			end
			for (int r = 0; r < RES; r++) free_q[r] <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_addr == CFG_PROCS) active_procs_q <= cfg_wdata;
				else active_res_q <= cfg_wdata[2:0];
			end
			if (cmd.load) begin
				for (int r = 0; r < RES; r++) begin
					if (kind_q == KIND_HELD && int'(proc_q) < PROCS)
						held_q[pidx][r] <= COUNT_BITS'(amt_q[r]);
					if (kind_q == KIND_CEIL && int'(proc_q) < PROCS)
						ceil_q[pidx][r] <= COUNT_BITS'(amt_q[r]);
					if (kind_q == KIND_FREE)
						free_q[r] <= COUNT_BITS'(amt_q[r]);
				end
			end
			if (cmd.start_scan) begin
				done_q <= '0;
				idx_q <= '0;
				cnt_q <= '0;
				emit_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (row_ok) begin
					done_q[idx_q] <= 1'b1;
				end
				cnt_q <= cnt_next;
				idx_q <= pass_end ? '0 : idx_q + PW'(1);
				found_q <= pass_end ? 1'b0 : (found_q || row_ok);
			end
			if (cmd.commit) begin
				for (int r = 0; r < RES; r++) begin
					held_q[pidx][r] <= thp_q[r];
					if (r < int'(m)) free_q[r] <= free_q[r] - COUNT_BITS'(amt_q[r]);
				end
			end
			if (cmd.emit_valid) begin
				out_valid_q <= 1'b1;
				if (cmd.emit_seq) emit_q <= emit_q + CW'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			proc_q <= in_proc;
			for (int r = 0; r < RES; r++) amt_q[r] <= in_amt[8*r +: 8];
		end
		if (cmd.start_scan) begin
			for (int r = 0; r < RES; r++) begin
				if (r < int'(m)) begin
					work_q[r] <= WW'(free_q[r]) - WW'(amt_q[r]);
					thp_q[r] <= held_q[pidx][r] + COUNT_BITS'(amt_q[r]);
				end else begin
					work_q[r] <= WW'(free_q[r]);
					thp_q[r] <= held_q[pidx][r];
				end
			end
		end
		if (cmd.scan_step && row_ok) begin
			seq_q[cnt_q[PW-1:0]] <= idx_q;
			for (int r = 0; r < RES; r++)
				if (r < int'(m)) work_q[r] <= work_q[r] + WW'(row_h[r]);
		end
		if (cmd.emit_valid) begin
			out_status_q <= cmd.emit_status;
			out_seq_q <= cmd.emit_seq ? 3'(seq_q[emit_q[PW-1:0]]) : 3'd0;
			out_last_q <= cmd.emit_seq ? sts.emit_last : 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_seq = out_seq_q;
	assign out_last = out_last_q;
endmodule
`default_nettype wire

// File: design/bankers_safety_grant_top.sv
// flow: after accept, a check state, then a row-serial scan of one row per cycle in
// index order, then the emitted words, each held while the output stalls; a load or
// rejected request goes from check straight to its single result word
// throughput: one word in at a time, taken again once its last result is registered
// reset: arst_n clears tables to zero, active_procs to 8, active_res to 4, no outputs
`default_nettype none
module bankers_safety_grant_top import bsg_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire         cfg_addr,
	input  wire  [3:0]  cfg_wdata,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [39:0] s_axis_tdata, // proc_index, amount_a, amount_b, amount_c, amount_d
	input  wire  [1:0]  s_axis_tuser, // kind
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata, // seq_proc
	output logic [2:0]  m_axis_tuser, // status
	output logic        m_axis_tlast
);
	cmd_t cmd;
	sts_t sts;
	logic [2:0] seq;

	bsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.in_kind    (s_axis_tuser),
		.in_proc    (s_axis_tdata[2:0]),
		.in_amt     (s_axis_tdata[34:3]),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (m_axis_tuser),
		.out_seq    (seq),
		.out_last   (m_axis_tlast),
		.cmd        (cmd),
		.sts        (sts)
	);

	assign m_axis_tdata = {5'd0, seq};
endmodule
`default_nettype wire

// File: design/bsg_checker.sv
// port-level checker for the safety grant block and its bind
`default_nettype none
`include "bankers_safety_grant_top_assert.svh"
module bsg_checker import bsg_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tvalid,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [7:0]  m_axis_tdata,
	input wire [2:0]  m_axis_tuser,
	input wire        m_axis_tlast
);
	`BSG_ASSERT(a_status_range, !m_axis_tvalid || m_axis_tuser <= ST_UNSAFE, "bad status")
	`BSG_ASSERT(a_single_last, !m_axis_tvalid || m_axis_tuser == ST_GRANTED || m_axis_tlast, "reject not last")
	`BSG_ASSERT(a_zero_seq, !m_axis_tvalid || m_axis_tuser == ST_GRANTED || m_axis_tdata == 8'd0, "seq not zero")
	`BSG_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
	`BSG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "word dropped")
endmodule

bind bankers_safety_grant_top bsg_checker u_bsg_checker (.*);
`default_nettype wire
